// File: hdl/rwh_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rwh_pkg
// Shared types and constants of the rolling window hash: field widths, the
// hash modulus, the command passed from front to back, and the reduction
// unit request and response.
// ----------------------------------------------------------------------------
package rwh_pkg;

    localparam int TOKEN_W     = 16;
    localparam int HASH_W      = 30;
    localparam int CFG_W       = 5;
    localparam int PROD_W      = 46;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [HASH_W-1:0] HASH_MOD     = 30'd1000000007;
    localparam logic [CFG_W-1:0]  WINDOW_RESET = 5'd12;

    // floor(2^48 / HASH_MOD), quotient estimate for the reduction unit
    localparam logic [18:0] BARRETT_M = 19'd281474;

    typedef logic [1:0] t_op;
    localparam t_op OP_HASH = 2'd0;
    localparam t_op OP_WGT  = 2'd1;
    localparam t_op OP_TERM = 2'd2;

    typedef struct packed {
        logic [TOKEN_W-1:0] token;
        logic [TOKEN_W-1:0] old_token;
        logic               clear;
        logic               roll;
        logic               wgt_upd;
        logic               emit;
    } t_cmd;

    typedef struct packed {
        logic              valid;
        t_op               tag;
        logic [PROD_W-1:0] x;
    } t_red_req;

    typedef struct packed {
        logic              valid;
        t_op               tag;
        logic [HASH_W-1:0] r;
    } t_red_rsp;

endpackage

// File: hdl/rwh_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rwh_front
// Accepts tokens, tracks the window fill, keeps the token history and
// classifies each token as a fill or a roll step for the back end.
// ----------------------------------------------------------------------------
module rwh_front #(
    parameter int MAX_WINDOW = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [rwh_pkg::CFG_W-1:0]   i_cfg_wdata,
    input  logic                        i_push,
    output logic                        o_full,
    input  logic [rwh_pkg::TOKEN_W-1:0] i_token,
    input  logic                        i_first,
    output rwh_pkg::t_cmd               o_cmd,
    output logic                        o_q_push,
    input  logic                        i_q_full
);
    import rwh_pkg::*;

    localparam int PTR_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int SUM_W = PTR_W + 2;
    localparam logic [CFG_W-1:0] MAX_W =
        (MAX_WINDOW >= (1 << CFG_W)) ? {CFG_W{1'b1}} : CFG_W'(MAX_WINDOW);

    logic [TOKEN_W-1:0] r_hist [MAX_WINDOW];
    logic [TOKEN_W-1:0] r_old;
    logic [CFG_W-1:0]   r_window;
    logic [CFG_W-1:0]   r_fill;
    logic [CFG_W-1:0]   n_fill;
    logic [PTR_W-1:0]   r_ptr;
    logic               r_s1_valid;
    t_cmd               r_s1_cmd;
    t_cmd               n_cmd;

    logic [CFG_W-1:0]   w_eff;
    logic [CFG_W-1:0]   w_fc;
    logic [CFG_W:0]     w_fc_inc;
    logic [SUM_W-1:0]   w_sum;
    logic [SUM_W-1:0]   w_rd_idx;
    logic               w_accept;

    assign o_full   = r_s1_valid && i_q_full;
    assign o_q_push = r_s1_valid && !i_q_full;
    assign w_accept = i_push && !o_full;

    always_comb begin
        if (r_window == '0) begin
            w_eff = CFG_W'(1);
        end else if (r_window > MAX_W) begin
            w_eff = MAX_W;
        end else begin
            w_eff = r_window;
        end
    end

    // oldest slot of the window sits W entries behind the write pointer
    assign w_sum    = SUM_W'(r_ptr) + SUM_W'(MAX_WINDOW) - SUM_W'(w_eff);
    assign w_rd_idx = (w_sum >= SUM_W'(MAX_WINDOW)) ? w_sum - SUM_W'(MAX_WINDOW) : w_sum;

    always_comb begin
        w_fc          = i_first ? '0 : r_fill;
        w_fc_inc      = {1'b0, w_fc} + (CFG_W+1)'(1);
        n_cmd.token   = i_token;
        n_cmd.old_token = '0;
        n_cmd.clear   = i_first;
        n_cmd.roll    = (w_fc >= w_eff);
        n_cmd.wgt_upd = !n_cmd.roll && (w_fc_inc < {1'b0, w_eff});
        n_cmd.emit    = n_cmd.roll || (w_fc_inc == {1'b0, w_eff});
        n_fill        = n_cmd.roll ? w_fc : w_fc_inc[CFG_W-1:0];
    end

    always_comb begin
        o_cmd           = r_s1_cmd;
        o_cmd.old_token = r_old;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window   <= WINDOW_RESET;
            r_fill     <= '0;
            r_ptr      <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_window <= i_cfg_wdata;
                r_fill   <= '0;
            end else if (w_accept) begin
                r_fill <= n_fill;
            end
            if (w_accept) begin
                r_ptr <= (r_ptr == PTR_W'(MAX_WINDOW - 1)) ? '0 : r_ptr + PTR_W'(1);
            end
            if (w_accept) begin
                r_s1_valid <= 1'b1;
            end else if (o_q_push) begin
                r_s1_valid <= 1'b0;
            end
        end
    end

    // read the oldest token before the new one overwrites its slot
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_cmd       <= n_cmd;
            r_old          <= r_hist[w_rd_idx[PTR_W-1:0]];
            r_hist[r_ptr]  <= i_token;
        end
    end

endmodule

// File: hdl/rwh_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rwh_fifo
// Short command queue between the front and the back end.
// ----------------------------------------------------------------------------
module rwh_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  rwh_pkg::t_cmd i_data,
    output logic          o_full,
    input  logic          i_pop,
    output rwh_pkg::t_cmd o_data,
    output logic          o_empty
);
    import rwh_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_cmd             r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_count;
    logic             w_wr_en;
    logic             w_rd_en;

    assign o_full  = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd];
    assign w_wr_en = i_push && !o_full;
    assign w_rd_en = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (w_wr_en) begin
                r_wr <= (r_wr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr + PTR_W'(1);
            end
            if (w_rd_en) begin
                r_rd <= (r_rd == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd + PTR_W'(1);
            end
            if (w_wr_en && !w_rd_en) begin
                r_count <= r_count + CNT_W'(1);
            end else if (w_rd_en && !w_wr_en) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

// File: hdl/rwh_modred.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rwh_modred
// Pipelined reduction modulo 1000000007 of values below 2^46, in stages:
// quotient estimate, quotient times modulus,
// subtract and one correction.
// ----------------------------------------------------------------------------
module rwh_modred (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  rwh_pkg::t_red_req i_req,
    output rwh_pkg::t_red_rsp o_rsp
);
    import rwh_pkg::*;

    localparam int A_LSB   = 28;
    localparam int A_W     = PROD_W - A_LSB;
    localparam int QM_W    = A_W + 19;
    localparam int Q_SHIFT = 20;
    localparam int Q_W     = QM_W - Q_SHIFT;
    localparam int RES_W   = HASH_W + 1;

    logic              r_s0_valid, r_s1_valid, r_s2_valid, r_s3_valid;
    t_op               r_s0_tag, r_s1_tag, r_s2_tag, r_s3_tag;
    logic [PROD_W-1:0] r_s0_x;
    logic [RES_W-1:0]  r_s1_xl, r_s2_xl;
    logic [Q_W-1:0]    r_s1_q;
    logic [RES_W-1:0]  r_s2_qp;
    logic [HASH_W-1:0] r_s3_r;

    logic [QM_W-1:0]   w_qm;
    logic [RES_W-1:0]  w_qp;
    logic [RES_W-1:0]  w_diff;
    logic [RES_W-1:0]  w_corr;

    // estimate never exceeds the true quotient and trails it by at most one
    assign w_qm   = QM_W'(r_s0_x[PROD_W-1:A_LSB]) * QM_W'(BARRETT_M);
    assign w_qp   = RES_W'(r_s1_q) * RES_W'(HASH_MOD);
    assign w_diff = r_s2_xl - r_s2_qp;
    assign w_corr = (w_diff >= {1'b0, HASH_MOD}) ? w_diff - {1'b0, HASH_MOD} : w_diff;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_valid <= 1'b0;
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
        end else begin
            r_s0_valid <= i_req.valid;
            r_s1_valid <= r_s0_valid;
            r_s2_valid <= r_s1_valid;
            r_s3_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s0_tag <= i_req.tag;
        r_s0_x   <= i_req.x;
        r_s1_tag <= r_s0_tag;
        r_s1_xl  <= r_s0_x[RES_W-1:0];
        r_s1_q   <= w_qm[Q_SHIFT +: Q_W];
        r_s2_tag <= r_s1_tag;
        r_s2_xl  <= r_s1_xl;
        r_s2_qp  <= w_qp;
        r_s3_tag <= r_s2_tag;
        r_s3_r   <= w_corr[HASH_W-1:0];
    end

    assign o_rsp.valid = r_s3_valid;
    assign o_rsp.tag   = r_s3_tag;
    assign o_rsp.r     = r_s3_r;

endmodule

// File: hdl/rwh_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rwh_back
// Executes fill and roll commands on the running hash and the oldest-token
// weight through the shared reduction unit, and holds the result register.
// ----------------------------------------------------------------------------
module rwh_back (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  rwh_pkg::t_cmd              i_cmd,
    input  logic                       i_q_empty,
    output logic                       o_q_pop,
    output rwh_pkg::t_red_req          o_req,
    input  rwh_pkg::t_red_rsp          i_rsp,
    input  logic                       i_pop,
    output logic                       o_empty,
    output logic [rwh_pkg::HASH_W-1:0] o_hash_value
);
    import rwh_pkg::*;

    localparam logic [2:0] S_IDLE       = 3'd0;
    localparam logic [2:0] S_TERM_WAIT  = 3'd1;
    localparam logic [2:0] S_HASH_ISSUE = 3'd2;
    localparam logic [2:0] S_HASH_WAIT  = 3'd3;
    localparam logic [2:0] S_HOLD       = 3'd4;

    logic [2:0]        r_state, n_state;
    logic [HASH_W-1:0] r_hash, n_hash;
    logic [HASH_W-1:0] r_wgt, n_wgt;
    logic              r_out_valid, n_out_valid;
    logic [HASH_W-1:0] r_out_hash, n_out_hash;
    t_cmd              r_cmd;

    logic [HASH_W-1:0] w_eff_hash;
    logic [HASH_W-1:0] w_eff_wgt;
    logic              w_out_free;

    // v * 257 + t
    function automatic logic [PROD_W-1:0] shift_in(input logic [HASH_W-1:0] v,
                                                   input logic [TOKEN_W-1:0] t);
        shift_in = PROD_W'({v, 8'b0}) + PROD_W'(v) + PROD_W'(t);
    endfunction

    // (h - t) mod p for h, t below p
    function automatic logic [HASH_W-1:0] sub_mod(input logic [HASH_W-1:0] h,
                                                  input logic [HASH_W-1:0] t);
        logic [HASH_W:0] d;
        d = {1'b0, h} - {1'b0, t};
        if (d[HASH_W]) begin
            d = d + {1'b0, HASH_MOD};
        end
        sub_mod = d[HASH_W-1:0];
    endfunction

    assign w_eff_hash = i_cmd.clear ? '0 : r_hash;
    assign w_eff_wgt  = i_cmd.clear ? HASH_W'(1) : r_wgt;
    assign w_out_free = !r_out_valid || i_pop;

    always_comb begin
        n_state     = r_state;
        n_hash      = r_hash;
        n_wgt       = r_wgt;
        n_out_valid = r_out_valid && !i_pop;
        n_out_hash  = r_out_hash;
        o_q_pop     = 1'b0;
        o_req.valid = 1'b0;
        o_req.tag   = OP_HASH;
        o_req.x     = '0;
        unique case (r_state)
            S_IDLE: begin
                if (!i_q_empty) begin
                    o_q_pop     = 1'b1;
                    n_hash      = w_eff_hash;
                    n_wgt       = w_eff_wgt;
                    o_req.valid = 1'b1;
                    if (i_cmd.roll) begin
                        o_req.tag = OP_TERM;
                        o_req.x   = PROD_W'(i_cmd.old_token) * PROD_W'(w_eff_wgt);
                        n_state   = S_TERM_WAIT;
                    end else if (i_cmd.wgt_upd) begin
                        // weight goes first; the hash op follows next cycle
                        o_req.tag = OP_WGT;
                        o_req.x   = shift_in(w_eff_wgt, '0);
                        n_state   = S_HASH_ISSUE;
                    end else begin
                        o_req.tag = OP_HASH;
                        o_req.x   = shift_in(w_eff_hash, i_cmd.token);
                        n_state   = S_HASH_WAIT;
                    end
                end
            end
            S_TERM_WAIT: begin
                if (i_rsp.valid) begin
                    n_hash  = sub_mod(r_hash, i_rsp.r);
                    n_state = S_HASH_ISSUE;
                end
            end
            S_HASH_ISSUE: begin
                o_req.valid = 1'b1;
                o_req.tag   = OP_HASH;
                o_req.x     = shift_in(r_hash, r_cmd.token);
                n_state     = S_HASH_WAIT;
            end
            S_HASH_WAIT: begin
                if (i_rsp.valid) begin
                    if (i_rsp.tag == OP_WGT) begin
                        n_wgt = i_rsp.r;
                    end else begin
                        n_hash = i_rsp.r;
                        if (!r_cmd.emit) begin
                            n_state = S_IDLE;
                        end else if (w_out_free) begin
                            n_out_valid = 1'b1;
                            n_out_hash  = i_rsp.r;
                            n_state     = S_IDLE;
                        end else begin
                            n_state = S_HOLD;
                        end
                    end
                end
            end
            S_HOLD: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_hash  = r_hash;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        // a window size write restarts the window
        if (i_cfg_we) begin
            n_hash = '0;
            n_wgt  = HASH_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_hash      <= '0;
            r_wgt       <= HASH_W'(1);
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_hash      <= n_hash;
            r_wgt       <= n_wgt;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_hash <= n_out_hash;
        if (o_q_pop) begin
            r_cmd <= i_cmd;
        end
    end

    assign o_empty      = !r_out_valid;
    assign o_hash_value = r_out_hash;

endmodule

// File: hdl/rolling_window_hash.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rolling_window_hash
// Rolling polynomial hash, base 257 modulo 1000000007, over the last W
// tokens of a stream.
// ----------------------------------------------------------------------------
// Usage:
//   Tokens enter through push/full; a token transfers on a clock edge with
//   push high and full low. first_of_sequence restarts the window at that
//   token. Hashes leave through empty/pop; o_hash_value is valid while empty
//   is low and transfers on an edge with pop high.
//   The first W-1 tokens of a sequence give no hash; every later token gives
//   one. Writing i_cfg_wdata with i_cfg_we sets W (0 acts as 1, values above
//   MAX_WINDOW act as MAX_WINDOW) and restarts the window; write only while
//   the block is idle.
//   Throughput: the back end finishes each token before it takes the next.
//   A filling token makes one trip through the four-stage shared modular
//   reduction unit; while the oldest-token weight is still growing, the
//   weight and hash ops enter it back to back; a rolling token makes two
//   trips in series, oldest term first. Each token adds issue and write-back.
//   A stalled receiver holds the result register; a four-entry command queue
//   keeps the front taking tokens until it fills, then full rises.
//   Synchronous reset empties all queues, restarts the window and sets W
//   to 12. The token history needs no clearing.
// ----------------------------------------------------------------------------
module rolling_window_hash #(
    parameter int MAX_WINDOW = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [rwh_pkg::CFG_W-1:0]   i_cfg_wdata,
    input  logic                        push,
    output logic                        full,
    input  logic [rwh_pkg::TOKEN_W-1:0] i_token,
    input  logic                        i_first_of_sequence,
    output logic                        empty,
    input  logic                        pop,
    output logic [rwh_pkg::HASH_W-1:0]  o_hash_value
);
    import rwh_pkg::*;

    t_cmd     w_front_cmd;
    t_cmd     w_back_cmd;
    logic     w_q_push;
    logic     w_q_full;
    logic     w_q_pop;
    logic     w_q_empty;
    t_red_req w_req;
    t_red_rsp w_rsp;

    rwh_front #(
        .MAX_WINDOW (MAX_WINDOW)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_push      (push),
        .o_full      (full),
        .i_token     (i_token),
        .i_first     (i_first_of_sequence),
        .o_cmd       (w_front_cmd),
        .o_q_push    (w_q_push),
        .i_q_full    (w_q_full)
    );

    rwh_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_q_push),
        .i_data  (w_front_cmd),
        .o_full  (w_q_full),
        .i_pop   (w_q_pop),
        .o_data  (w_back_cmd),
        .o_empty (w_q_empty)
    );

    rwh_modred u_modred (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    rwh_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cmd        (w_back_cmd),
        .i_q_empty    (w_q_empty),
        .o_q_pop      (w_q_pop),
        .o_req        (w_req),
        .i_rsp        (w_rsp),
        .i_pop        (pop),
        .o_empty      (empty),
        .o_hash_value (o_hash_value)
    );

endmodule

// File: hdl/rwh_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rwh_checker
// Port-level checks of the rolling window hash, bound to the top level.
// ----------------------------------------------------------------------------
module rwh_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       full,
    input logic                       empty,
    input logic                       pop,
    input logic [rwh_pkg::HASH_W-1:0] o_hash_value
);
    import rwh_pkg::*;

    // reset drains both sides
    a_reset_drain: assert property (@(posedge i_clk)
        !i_rst_n |=> empty && !full)
        else $error("empty/full wrong after reset");

    // every offered hash is a residue
    a_hash_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_hash_value < HASH_MOD))
        else $error("hash value not reduced");

    // a stalled result stays put
    a_result_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rst_n && !empty && !pop |=> !empty && $stable(o_hash_value))
        else $error("waiting result changed");

endmodule

bind rolling_window_hash rwh_checker u_rwh_checker (.*);

// File: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for rolling_window_hash. A queue of token, window-length
// and pause entries feeds a falling-edge driver. A rising-edge monitor scores
// each hash transfer against a bit-exact software copy of the rolling hash.
// Both handshake sides idle at random, and the receiver holds off once for a
// long stretch so that the block backs up.
// ----------------------------------------------------------------------------
module testbench;

    import rwh_pkg::*;

    localparam int              MAX_WIN   = 16;
    localparam longint unsigned HASH_P    = longint'(HASH_MOD);
    localparam longint unsigned HASH_BASE = 257;
    localparam int              SETTLE    = 64;    // back end drain before a write
    localparam int              HOLD_LEN  = 300;
    localparam int              PHASE_LEN = 165;

    typedef enum logic [1:0] {
        ENTRY_TOKEN,
        ENTRY_WINDOW,
        ENTRY_PAUSE
    } t_entry_kind;

    typedef struct {
        t_entry_kind        kind;
        logic [TOKEN_W-1:0] token;
        logic               first;
        logic [CFG_W-1:0]   window;
    } t_entry;

    logic               i_clk               = 1'b0;
    logic               i_rst_n             = 1'b0;
    logic               i_cfg_we            = 1'b0;
    logic [CFG_W-1:0]   i_cfg_wdata         = '0;
    logic               push                = 1'b0;
    logic               full;
    logic [TOKEN_W-1:0] i_token             = '0;
    logic               i_first_of_sequence = 1'b0;
    logic               empty;
    logic               pop                 = 1'b0;
    logic [HASH_W-1:0]  o_hash_value;

    rolling_window_hash #(
        .MAX_WINDOW (MAX_WIN)
    ) u_top (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_wdata         (i_cfg_wdata),
        .push                (push),
        .full                (full),
        .i_token             (i_token),
        .i_first_of_sequence (i_first_of_sequence),
        .empty               (empty),
        .pop                 (pop),
        .o_hash_value        (o_hash_value)
    );

    always #5 i_clk = ~i_clk;

    // stimulus and scoreboard
    t_entry             stim_q[$];
    logic [HASH_W-1:0]  pending_hashes[$];
    t_entry             offered;
    int unsigned        offered_cnt  = 0;
    int unsigned        accepted_cnt = 0;
    int unsigned        cycle_cnt    = 0;
    int unsigned        settle_cnt   = 0;
    int unsigned        err_cnt      = 0;
    int unsigned        hold_cnt     = 0;
    logic               hold_done    = 1'b0;

    // software copy of the hash state
    logic [TOKEN_W-1:0] win_tokens[MAX_WIN];
    int unsigned        win_ptr;
    int unsigned        win_fill;
    longint unsigned    win_hash;
    longint unsigned    win_weight;
    logic [CFG_W-1:0]   win_size;

    function automatic void restart_window();
        win_fill   = 0;
        win_hash   = 0;
        win_weight = 1;
    endfunction

    function automatic void roll_hash(input logic [TOKEN_W-1:0] tok, input logic first);
        int unsigned     w;
        int unsigned     slot;
        longint unsigned term;
        w = (win_size == 0) ? 1 : ((win_size > MAX_WIN) ? MAX_WIN : win_size);
        if (first) restart_window();
        if (win_fill < w) begin
            win_hash = (win_hash * HASH_BASE + tok) % HASH_P;
            if (win_fill + 1 < w) win_weight = (win_weight * HASH_BASE) % HASH_P;
            win_fill++;
            if (win_fill == w)
                pending_hashes.insert(pending_hashes.size(), win_hash[HASH_W-1:0]);
        end else begin
            // drop the oldest weighted term, then shift the new token in
            slot     = (win_ptr + MAX_WIN - w) % MAX_WIN;
            term     = (longint'(win_tokens[slot]) * win_weight) % HASH_P;
            win_hash = (win_hash + HASH_P - term) % HASH_P;
            win_hash = (win_hash * HASH_BASE + tok) % HASH_P;
            pending_hashes.insert(pending_hashes.size(), win_hash[HASH_W-1:0]);
        end
        win_tokens[win_ptr] = tok;
        win_ptr = (win_ptr + 1) % MAX_WIN;
    endfunction

    function automatic void add_token(input logic [TOKEN_W-1:0] tok, input logic first);
        t_entry e;
        e.kind   = ENTRY_TOKEN;
        e.token  = tok;
        e.first  = first;
        e.window = '0;
        stim_q.insert(stim_q.size(), e);
    endfunction

    function automatic void add_marker(input t_entry_kind kind, input logic [CFG_W-1:0] w);
        t_entry e;
        e.kind   = kind;
        e.token  = '0;
        e.first  = 1'b0;
        e.window = w;
        stim_q.insert(stim_q.size(), e);
    endfunction

    function automatic logic [TOKEN_W-1:0] pick_token();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 5) return '0;
        if (r < 10) return '1;
        return TOKEN_W'($urandom_range(65535));
    endfunction

    function automatic logic side_idles();
        if (cycle_cnt >= 4000 && cycle_cnt < 7000) return 1'b0;
        return ($urandom_range(99) < 30);
    endfunction

    task automatic flag_error(input logic [HASH_W-1:0] exp_val, input logic have_exp);
        err_cnt++;
        if (err_cnt <= 10) begin
            if (have_exp)
                $display("hash mismatch at %0t: expected %0d, got %0d",
                         $realtime, exp_val, o_hash_value);
            else
                $display("unexpected hash at %0t: got %0d", $realtime, o_hash_value);
        end
    endtask

    // rising edge: score results, then record accepted tokens and writes
    always @(posedge i_clk) begin
        logic [HASH_W-1:0] exp_val;
        cycle_cnt <= cycle_cnt + 1;
        if (i_rst_n) begin
            if (pop && !empty) begin
                if (pending_hashes.size() == 0) begin
                    flag_error('0, 1'b0);
                end else begin
                    exp_val = pending_hashes.pop_front();
                    if (o_hash_value !== exp_val) flag_error(exp_val, 1'b1);
                end
            end
            if (push && !full) begin
                roll_hash(offered.token, offered.first);
                accepted_cnt++;
            end
            if (i_cfg_we) begin
                win_size = i_cfg_wdata;
                restart_window();
            end
        end
    end

    // one long receiver hold-off, early in the random part
    always @(posedge i_clk) begin
        if (!hold_done && accepted_cnt >= 400) begin
            hold_cnt  <= HOLD_LEN;
            hold_done <= 1'b1;
        end else if (hold_cnt > 0) begin
            hold_cnt <= hold_cnt - 1;
        end
    end

    // sender
    always @(negedge i_clk) begin
        logic             nxt_push;
        logic             nxt_we;
        logic [CFG_W-1:0] nxt_wdata;
        nxt_push  = push;
        nxt_we    = 1'b0;
        nxt_wdata = i_cfg_wdata;
        if (!i_rst_n) begin
            nxt_push = 1'b0;
        end else if (push && accepted_cnt != offered_cnt) begin
            // hold until the transfer happens
            nxt_push = 1'b1;
        end else if (stim_q.size() == 0) begin
            nxt_push = 1'b0;
        end else if (stim_q[0].kind == ENTRY_TOKEN) begin
            if (side_idles()) begin
                nxt_push = 1'b0;
            end else begin
                offered = stim_q.pop_front();
                offered_cnt++;
                i_token             <= offered.token;
                i_first_of_sequence <= offered.first;
                nxt_push = 1'b1;
            end
        end else begin
            // drain everything, let the back end settle, then write or resume
            nxt_push = 1'b0;
            if (pending_hashes.size() == 0) settle_cnt = settle_cnt + 1;
            else settle_cnt = 0;
            if (settle_cnt >= SETTLE) begin
                if (stim_q[0].kind == ENTRY_WINDOW) begin
                    nxt_we    = 1'b1;
                    nxt_wdata = stim_q[0].window;
                end
                void'(stim_q.pop_front());
                settle_cnt = 0;
            end
        end
        push        <= nxt_push;
        i_cfg_we    <= nxt_we;
        i_cfg_wdata <= nxt_wdata;
    end

    // receiver
    always @(negedge i_clk) begin
        pop <= i_rst_n && (hold_cnt == 0) && !side_idles();
    end

    initial begin
        int unsigned  seq_len;
        int unsigned  made;
        logic         noisy;
        logic [CFG_W-1:0] phase_win[10] = '{5'd16, 5'd31, 5'd1, 5'd0, 5'd17,
                                            5'd12, 5'd8, 5'd3, 5'd0, 5'd0};
        phase_win[8] = CFG_W'($urandom_range(31));
        phase_win[9] = CFG_W'($urandom_range(1, 16));

        for (int i = 0; i < MAX_WIN; i++) win_tokens[i] = '0;
        win_ptr  = 0;
        win_size = WINDOW_RESET;
        restart_window();

        // directed: single-token window, zero window, restart mid-window, extremes
        add_marker(ENTRY_WINDOW, 5'd1);
        add_token(16'hFFFF, 1'b1);
        add_token(16'h0000, 1'b0);
        add_token(16'h5555, 1'b0);
        add_marker(ENTRY_WINDOW, 5'd0);
        add_token(16'hAAAA, 1'b0);
        add_token(16'hFFFF, 1'b1);
        add_marker(ENTRY_WINDOW, 5'd2);
        add_token(16'h0001, 1'b0);
        add_token(16'h0002, 1'b0);
        add_token(16'h0003, 1'b1);
        add_token(16'h0004, 1'b0);
        add_token(16'h0005, 1'b0);
        add_marker(ENTRY_WINDOW, 5'd3);
        add_token(16'hFFFF, 1'b0);
        add_token(16'hFFFF, 1'b0);
        add_token(16'hFFFF, 1'b0);
        add_token(16'hFFFF, 1'b0);
        add_token(16'h0000, 1'b0);
        add_token(16'h0000, 1'b0);

        // random phases: mostly clean sequences, some with scattered restarts
        for (int p = 0; p < 10; p++) begin
            add_marker(ENTRY_WINDOW, phase_win[p]);
            made = 0;
            while (made < PHASE_LEN) begin
                seq_len = $urandom_range(1, 40);
                noisy   = ($urandom_range(9) == 0);
                for (int k = 0; k < seq_len; k++) begin
                    if (noisy) add_token(pick_token(), ($urandom_range(3) == 0));
                    else add_token(pick_token(), (k == 0));
                end
                made += seq_len;
                if (p == 4 && made >= PHASE_LEN / 2 && made < PHASE_LEN / 2 + 40)
                    add_marker(ENTRY_PAUSE, '0);
            end
        end

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        wait (stim_q.size() == 0 && accepted_cnt == offered_cnt &&
              pending_hashes.size() == 0);
        repeat (100) @(posedge i_clk);

        if (err_cnt == 0 && pending_hashes.size() == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("testbench NOT OK");
        $finish;
    end

endmodule
